[rtl/core/mrt_pkg.sv]
// shared types, codes and constants of the memory region table
// no dependencies; every other file of the block uses it by scoped names
package mrt_pkg;

  localparam int unsigned REGION_W        = 64;
  localparam int unsigned REGION_SHIFT    = 40;
  localparam int unsigned MAX_REGIONS_DEF = 16;
  localparam int unsigned CFG_AW          = 4;
  localparam int unsigned CFG_DW          = 64;

  // request codes; the spare code behaves as a check
  typedef enum logic [1:0] {
    OP_ADD_NUM  = 2'd0,
    OP_ADD_ADDR = 2'd1,
    OP_CHECK    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_ILLEGAL = 3'd1,
    STS_PRESENT = 3'd2,
    STS_FULL    = 3'd3,
    STS_INVALID = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CMP,
    FSM_DEC
  } fsm_t;

  // register select, paddr bit 3
  typedef enum logic {
    REG_LOW  = 1'b0,
    REG_HIGH = 1'b1
  } reg_sel_t;

  // per-cycle control broadcast to the cell row
  typedef struct packed {
    logic shift;
    logic cmp;
  } cell_ctl_t;

endpackage

[rtl/core/mrt_if.sv]
// valid/ready channel interfaces for request and result words
// depends on mrt_pkg for field widths
interface mrt_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     operation;
  logic [mrt_pkg::REGION_W-1:0]   region_number;
  logic [mrt_pkg::REGION_W-1:0]   address;

  modport src (output valid, operation, region_number, address, input ready);
  modport snk (input valid, operation, region_number, address, output ready);
endinterface

interface mrt_out_if;
  logic       valid;
  logic       ready;
  logic       passed;
  logic [2:0] status;

  modport src (output valid, passed, status, input ready);
  modport snk (input valid, passed, status, output ready);
endinterface

[rtl/core/mrt_cell.sv]
// one table cell: holds a region number, shifts it on, compares it to the key
// depends on mrt_pkg
module mrt_cell (
  input  logic                          clk,
  input  mrt_pkg::cell_ctl_t            ctl,
  input  logic                          occupied,
  input  logic [mrt_pkg::REGION_W-1:0]  key,
  input  logic [mrt_pkg::REGION_W-1:0]  din,
  output logic [mrt_pkg::REGION_W-1:0]  dout,
  output logic                          hit
);

  logic [mrt_pkg::REGION_W-1:0] entry_r;
  logic                         hit_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry_r <= din;
    end
    if (ctl.cmp) begin
      hit_r <= occupied && (entry_r == key);
    end
  end

  assign dout = entry_r;
  assign hit  = hit_r;

endmodule

[rtl/core/mrt_chain.sv]
// row of table cells; new numbers enter cell 0 and push older ones along
// depends on mrt_pkg and mrt_cell
module mrt_chain #(
  parameter int unsigned N  = mrt_pkg::MAX_REGIONS_DEF,
  parameter int unsigned CW = $clog2(N + 1)
) (
  input  logic                          clk,
  input  mrt_pkg::cell_ctl_t            ctl,
  input  logic [CW-1:0]                 count,
  input  logic [mrt_pkg::REGION_W-1:0]  key,
  output logic                          any_hit
);

  logic [mrt_pkg::REGION_W-1:0] link [N+1];
  logic [N-1:0]                 hits;

  assign link[0] = key;

  for (genvar i = 0; i < N; i++) begin : g_cell
    mrt_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occupied (count > CW'(i)),
      .key      (key),
      .din      (link[i]),
      .dout     (link[i+1]),
      .hit      (hits[i])
    );
  end

  // last cell's output only feeds the unused tail link
  logic unused_tail;
  assign unused_tail = ^link[N];

  assign any_hit = |hits;

endmodule

[rtl/core/memory_region_table_top.sv]
// a request word is registered, compared in the cell row and range tested
//   (compare state), then decided and appended if ok (decide state, held
//   while a result word is stalled); the next request enters as the result loads
// the result register holds a finished word while the next request is compared
// reset: rst_n synchronous active low clears count, fsm, result valid, bounds;
//   cell contents stay undefined, cells past the count never match
module memory_region_table_top #(
  parameter int unsigned MAX_REGIONS = mrt_pkg::MAX_REGIONS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mrt_in_if.snk                       in_ch,
  mrt_out_if.src                      out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrt_pkg::CFG_AW-1:0]  paddr,
  input  logic [mrt_pkg::CFG_DW-1:0]  pwdata,
  output logic [mrt_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);

  // ---------------------------------------------------------------------------
  // config registers: illegal range bounds, 64-bit at byte addresses 0 and 8
  // ---------------------------------------------------------------------------
  logic [mrt_pkg::CFG_DW-1:0] low_bound_r;
  logic [mrt_pkg::CFG_DW-1:0] high_bound_r;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_bound_r  <= '0;
      high_bound_r <= '0;
    end else if (cfg_wr) begin
      case (mrt_pkg::reg_sel_t'(paddr[3]))
        mrt_pkg::REG_LOW:  low_bound_r  <= pwdata;
        mrt_pkg::REG_HIGH: high_bound_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (mrt_pkg::reg_sel_t'(paddr[3]))
      mrt_pkg::REG_LOW:  prdata = low_bound_r;
      mrt_pkg::REG_HIGH: prdata = high_bound_r;
      default:           prdata = '0;
    endcase
  end

  // low address bits do not take part in the register decode
  logic unused_paddr;
  assign unused_paddr = ^{paddr[2:0], paddr[mrt_pkg::CFG_AW-1]};

  // ---------------------------------------------------------------------------
  // request capture and control state
  // ---------------------------------------------------------------------------
  mrt_pkg::fsm_t                 state_r, state_nxt;
  logic [1:0]                    op_r;
  logic [mrt_pkg::REGION_W-1:0]  key_r;
  logic                          illegal_r;
  logic [CW-1:0]                 count_r, count_nxt;
  logic                          out_valid_r;
  logic                          passed_r;
  logic [2:0]                    status_r;

  logic                          in_take;
  logic                          finish;
  logic                          any_hit;
  logic                          do_append;
  mrt_pkg::status_t              status_nxt;
  mrt_pkg::cell_ctl_t            cell_ctl;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mrt_pkg::FSM_IDLE: begin
        if (in_take) state_nxt = mrt_pkg::FSM_CMP;
      end
      mrt_pkg::FSM_CMP: begin
        state_nxt = mrt_pkg::FSM_DEC;
      end
      mrt_pkg::FSM_DEC: begin
        // a new request can be taken on the same edge the result loads
        if (finish) state_nxt = in_take ? mrt_pkg::FSM_CMP : mrt_pkg::FSM_IDLE;
      end
      default: state_nxt = mrt_pkg::FSM_IDLE;
    endcase
  end

  // outputs and decision
  always_comb begin
    finish     = (state_r == mrt_pkg::FSM_DEC) && (!out_valid_r || out_ch.ready);
    in_ch.ready = (state_r == mrt_pkg::FSM_IDLE) || finish;
    in_take    = in_ch.valid && in_ch.ready;

    do_append  = 1'b0;
    case (mrt_pkg::op_t'(op_r))
      mrt_pkg::OP_ADD_NUM, mrt_pkg::OP_ADD_ADDR: begin
        // refusal order: illegal range, then duplicate, then table full
        if (illegal_r) begin
          status_nxt = mrt_pkg::STS_ILLEGAL;
        end else if (any_hit) begin
          status_nxt = mrt_pkg::STS_PRESENT;
        end else if (count_r == CW'(MAX_REGIONS)) begin
          status_nxt = mrt_pkg::STS_FULL;
        end else begin
          status_nxt = mrt_pkg::STS_OK;
          do_append  = 1'b1;
        end
      end
      default: begin
        // check, also the spare op code
        status_nxt = any_hit ? mrt_pkg::STS_OK : mrt_pkg::STS_INVALID;
      end
    endcase

    cell_ctl.shift = finish && do_append;
    cell_ctl.cmp   = (state_r == mrt_pkg::FSM_CMP);
    count_nxt      = cell_ctl.shift ? count_r + CW'(1) : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrt_pkg::FSM_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r <= in_ch.operation;
      // add by number uses the number, otherwise the address's region bits
      if (mrt_pkg::op_t'(in_ch.operation) == mrt_pkg::OP_ADD_NUM) begin
        key_r <= in_ch.region_number;
      end else begin
        key_r <= mrt_pkg::REGION_W'(in_ch.address >> mrt_pkg::REGION_SHIFT);
      end
    end
    // range test runs beside the cell compare
    if (state_r == mrt_pkg::FSM_CMP) begin
      illegal_r <= (key_r > low_bound_r) && (key_r < high_bound_r);
    end
    if (finish) begin
      passed_r <= (status_nxt == mrt_pkg::STS_OK);
      status_r <= status_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // cell row: key compared in every occupied cell, appends shift in at cell 0
  // ---------------------------------------------------------------------------
  mrt_chain #(
    .N  (MAX_REGIONS),
    .CW (CW)
  ) u_chain (
    .clk     (clk),
    .ctl     (cell_ctl),
    .count   (count_r),
    .key     (key_r),
    .any_hit (any_hit)
  );

  assign out_ch.valid  = out_valid_r;
  assign out_ch.passed = passed_r;
  assign out_ch.status = status_r;

endmodule

[rtl/core/mrt_checker.sv]
// port-level checks on the memory region table, bound to the top level
// depends on mrt_pkg for status codes
module mrt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_passed,
  input logic [2:0] out_status
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_passed) && $stable(out_status))
    else $error("result word changed while stalled");

  // passed agrees with the ok status
  a_passed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_passed == (out_status == mrt_pkg::STS_OK)))
    else $error("passed does not match status");

  // a request is compared before the next can enter
  a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken during compare cycle");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind memory_region_table_top mrt_checker u_mrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_passed (out_ch.passed),
  .out_status (out_ch.status)
);

[dv/memory_region_table_checker.sv]
// result checker for the memory region table: watches both word channels and the
// register port, predicts each result word and compares it field by field
// depends on mrt_pkg and the channel interfaces in mrt_if.sv
module memory_region_table_checker #(
  parameter int unsigned MAX_REGIONS = mrt_pkg::MAX_REGIONS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mrt_in_if                          in_mon,
  mrt_out_if                         out_mon,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [mrt_pkg::CFG_AW-1:0] paddr,
  input  logic [mrt_pkg::CFG_DW-1:0] pwdata,
  input  logic [mrt_pkg::CFG_DW-1:0] prdata,
  output int unsigned                awaited,
  output int unsigned                mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import mrt_pkg::*;

  typedef struct packed {
    logic    passed;
    status_t status;
  } region_result_t;

  logic [REGION_W-1:0] low_bound;
  logic [REGION_W-1:0] high_bound;
  logic [REGION_W-1:0] held_regions[$];   // table contents in append order
  region_result_t      expected_results[$];
  int unsigned         fault_tally = 0;

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    fault_tally++;
  endtask

  function automatic logic region_held(input logic [REGION_W-1:0] num);
    foreach (held_regions[i]) begin
      if (held_regions[i] == num) return 1'b1;
    end
    return 1'b0;
  endfunction

  // illegal range first, then duplicate, then capacity
  function automatic status_t apply_region_add(input logic [REGION_W-1:0] num);
    if (num > low_bound && num < high_bound) return STS_ILLEGAL;
    if (region_held(num)) return STS_PRESENT;
    if (held_regions.size() >= MAX_REGIONS) return STS_FULL;
    held_regions = {held_regions, num};
    return STS_OK;
  endfunction

  function automatic region_result_t predict_region_result(
    input logic [1:0]          op,
    input logic [REGION_W-1:0] num,
    input logic [REGION_W-1:0] addr
  );
    region_result_t      res;
    logic [REGION_W-1:0] addr_region;
    addr_region = addr >> REGION_SHIFT;
    case (op)
      OP_ADD_NUM:  res.status = apply_region_add(num);
      OP_ADD_ADDR: res.status = apply_region_add(addr_region);
      default:     res.status = region_held(addr_region) ? STS_OK : STS_INVALID;
    endcase
    res.passed = (res.status == STS_OK);
    return res;
  endfunction

  always @(posedge clk) begin
    region_result_t      want;
    logic [REGION_W-1:0] bound_now;
    logic                high_sel;
    if (!rst_n) begin
      low_bound  = '0;
      high_bound = '0;
      held_regions.delete();
      expected_results.delete();
    end else begin
      if (psel && penable && pready) begin
        high_sel  = (reg_sel_t'(paddr[3]) == REG_HIGH);
        bound_now = high_sel ? high_bound : low_bound;
        if (pwrite) begin
          if (high_sel) high_bound = pwdata;
          else low_bound = pwdata;
        end else if (prdata !== bound_now) begin
          report_mismatch($sformatf("bound readback at %h: got %h, want %h",
                                    paddr, prdata, bound_now));
        end
      end
      // results leave before the request accepted on this edge is predicted
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with no request pending");
        end else begin
          want = expected_results.pop_front();
          if (out_mon.passed !== want.passed)
            report_mismatch($sformatf("passed: got %b, want %b", out_mon.passed, want.passed));
          if (out_mon.status !== want.status)
            report_mismatch($sformatf("status: got %0d, want %0d", out_mon.status, want.status));
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_results = {expected_results,
                            predict_region_result(in_mon.operation,
                                                  in_mon.region_number,
                                                  in_mon.address)};
    end
    awaited        <= expected_results.size();
    mismatch_count <= fault_tally;
  end

endmodule

[dv/testbench.sv]
// top of the memory region table testbench: clock, reset, request stimulus,
// register writes, result back-pressure and the verdict
// depends on mrt_pkg, mrt_if.sv, the block and memory_region_table_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mrt_pkg::*;

  localparam int unsigned         QUIET_LIMIT = 2000;  // cycles without any handshake
  localparam int unsigned         PHASE_ITEMS = 180;
  localparam int unsigned         MAX_GAP     = 20;
  localparam int unsigned         POOL_DEPTH  = 48;
  localparam logic [1:0]          OP_SPARE    = 2'd3;  // unused code, acts as a check
  localparam logic [REGION_W-1:0] ALL_ONES    = '1;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic              pready;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;

  int unsigned awaited;
  int unsigned mismatch_count;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // bounds as last written, used to aim numbers at the edges of the illegal range
  logic [REGION_W-1:0] low_setting  = '0;
  logic [REGION_W-1:0] high_setting = '0;
  // recently added numbers, reused so that duplicates and passing checks are common
  logic [REGION_W-1:0] sent_regions[$];

  mrt_in_if  in_ch();
  mrt_out_if out_ch();

  memory_region_table_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  memory_region_table_checker result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .awaited        (awaited),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: any word, result or register access restarts the count
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one register access: setup cycle, access cycle, then a cycle with psel low
  // so that back-to-back accesses never touch psel twice in one step
  task automatic bound_access(input reg_sel_t sel, input logic wr,
                              input logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write both bounds, then read both back (the checker compares the readback)
  task automatic set_bounds(input logic [REGION_W-1:0] low, input logic [REGION_W-1:0] high);
    bound_access(REG_LOW, 1'b1, low);
    bound_access(REG_HIGH, 1'b1, high);
    bound_access(REG_LOW, 1'b0, '0);
    bound_access(REG_HIGH, 1'b0, '0);
    low_setting  = low;
    high_setting = high;
  endtask

  // hold off requests until every result word is back, then let the block settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (4) @(posedge clk);
  endtask

  // offer one request word and return at the edge it is taken; valid stays high
  // across back-to-back words and drops when an idle gap is drawn or a drain begins
  task automatic send_request(input logic [1:0] op, input logic [REGION_W-1:0] num,
                              input logic [REGION_W-1:0] addr);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.region_number <= num;
    in_ch.address       <= addr;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_ADD_NUM) sent_regions = {sent_regions, num};
    else if (op == OP_ADD_ADDR) sent_regions = {sent_regions, addr >> REGION_SHIFT};
    if (sent_regions.size() > POOL_DEPTH) void'(sent_regions.pop_front());
  endtask

  // region numbers: reused ones, tiny ones, ones next to a bound, wide random
  // ones, and ones small enough to come out of an address
  function automatic logic [REGION_W-1:0] pick_region();
    case ($urandom_range(5))
      0, 1: begin
        if (sent_regions.size() == 0) return '0;
        return sent_regions[$urandom_range(sent_regions.size() - 1)];
      end
      2: return REGION_W'($urandom_range(255));
      3: begin
        if ($urandom_range(1)) return low_setting + $urandom_range(2) - 1;
        return high_setting + $urandom_range(2) - 1;
      end
      4: return {$urandom, $urandom};
      default: return REGION_W'($urandom & 32'h00ff_ffff);
    endcase
  endfunction

  // mostly addresses whose top bits name a chosen region, some fully random
  function automatic logic [REGION_W-1:0] pick_address();
    logic [REGION_W-1:0] region;
    logic [REGION_W-1:0] addr;
    region = pick_region();
    addr   = {$urandom, $urandom};
    if ($urandom_range(3) != 0) addr[63:40] = region[23:0];
    return addr;
  endfunction

  task automatic send_random_request();
    int unsigned pick;
    logic [1:0]  op;
    pick = $urandom_range(99);
    if (pick < 30) op = OP_ADD_NUM;
    else if (pick < 55) op = OP_ADD_ADDR;
    else if (pick < 90) op = OP_CHECK;
    else op = OP_SPARE;
    send_request(op, pick_region(), pick_address());
  endtask

  // one setting of the bounds and of the idling, with a full drain halfway
  task automatic run_phase(input logic [REGION_W-1:0] low, input logic [REGION_W-1:0] high,
                           input int unsigned src_pct, input int unsigned snk_pct);
    drain_results();
    set_bounds(low, high);
    send_idle_pct  = src_pct;
    recv_stall_pct = snk_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n == PHASE_ITEMS / 2) drain_results();
      send_random_request();
    end
  endtask

  initial begin
    logic [REGION_W-1:0] base;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_ADD_NUM;
    in_ch.region_number = '0;
    in_ch.address       = '0;
    out_ch.ready        = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    rst_n               = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, illegal range is 101..199
    set_bounds(64'd100, 64'd200);
    send_request(OP_CHECK, '0, '0);                               // empty table, invalid
    send_request(OP_SPARE, ALL_ONES, ALL_ONES);                   // spare code checks
    send_request(OP_ADD_NUM, '0, ALL_ONES);                       // lowest number
    send_request(OP_ADD_NUM, '0, '0);                             // duplicate
    send_request(OP_ADD_NUM, ALL_ONES, '0);                       // highest number
    send_request(OP_ADD_NUM, 64'd150, '0);                        // inside illegal range
    send_request(OP_ADD_NUM, 64'd101, '0);                        // just above low bound
    send_request(OP_ADD_NUM, 64'd199, '0);                        // just below high bound
    send_request(OP_ADD_NUM, 64'd100, '0);                        // bounds themselves are legal
    send_request(OP_ADD_NUM, 64'd200, '0);
    send_request(OP_ADD_ADDR, '0, ALL_ONES);                      // top region
    send_request(OP_ADD_ADDR, ALL_ONES, 64'h0000_00ff_ffff_ffff); // region zero, duplicate
    send_request(OP_ADD_ADDR, '0, 64'h0000_9600_0000_0000);       // region 150, illegal
    send_request(OP_CHECK, '0, ALL_ONES);                         // top region present
    send_request(OP_CHECK, '0, 64'h0000_00ab_cdef_0123);          // region zero present
    send_request(OP_CHECK, '0, 64'h0000_0500_0000_0000);          // region 5 absent
    send_request(OP_SPARE, '0, 64'h0000_c800_0000_0000);          // region 200 via spare code

    // random phases: bound extremes, empty and inverted ranges, idling on neither, one or both sides;
    // the table fills early and stays full since reset comes only once
    run_phase('0, '0, 0, 0);
    run_phase('0, ALL_ONES, 58, 0);
    run_phase(ALL_ONES, ALL_ONES, 0, 58);
    run_phase(64'd50, 64'd51, 9, 9);
    base = REGION_W'($urandom_range(300));
    run_phase(base, base + $urandom_range(400), 0, 0);
    run_phase(64'd300, 64'd10, 58, 0);
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 0, 58);
    run_phase(64'd2, 64'h100_0000, 9, 9);

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
